// ===== hdl/lmad_pkg.sv =====
package lmad_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 10;

  localparam int unsigned SUM_W     = 16;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned WIN_W     = 7;
  localparam int unsigned LIM_W     = 14;
  localparam int unsigned LUX_W     = 14;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned DIG_W     = 4;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned PRD_W     = 25;
  localparam int unsigned NUM_W     = 28;
  localparam int unsigned DEN_W     = 29;
  localparam int unsigned REM_W     = DEN_W + 1;
  localparam int unsigned NUM_HI_W  = NUM_W - QUO_W;

  localparam logic [WIN_W-1:0] WIN_RESET    = 7'd50;
  localparam logic [WIN_W-1:0] WIN_MAX      = 7'd64;
  localparam logic [LIM_W-1:0] DARK_RESET   = 14'd50;
  localparam logic [LIM_W-1:0] BRIGHT_RESET = 14'd200;
  localparam logic [LUX_W-1:0] LUX_MAX      = 14'd9999;

  // 4.88 mV/count, 48.88 and 5000 mV terms scaled to integers
  localparam logic [PRD_W-1:0] K_VSTEP = 25'd488;
  localparam logic [PRD_W-1:0] K_VREF  = 25'd500000;
  localparam logic [DEN_W-1:0] K_DEN   = 29'd4888;
  localparam logic [NUM_W-1:0] K_GAIN  = 28'd500;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_DARK   = 2'd1,
    CFG_BRIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LVL_DARK   = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_LIGHT  = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    DSEL_THOU = 2'd0,
    DSEL_HUND = 2'd1,
    DSEL_TENS = 2'd2
  } dsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_NUM,
    ST_LUX_START,
    ST_DIV_LUX,
    ST_DIGIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  acc_en;
    logic  div_avg_start;
    logic  prod_en;
    logic  num_en;
    logic  div_lux_start;
    logic  clip_en;
    logic  digit_en;
    dsel_e digit_sel;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_busy;
  } sts_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [DIG_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/lmad_intf.sv =====
interface lmad_in_if #(
  parameter int unsigned SAMPLE_BITS = lmad_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface lmad_out_if;
  logic                           valid;
  logic                           ready;
  logic [lmad_pkg::LUX_W-1:0]     lux;
  logic [lmad_pkg::SEG_W-1:0]     seg_thousands;
  logic [lmad_pkg::SEG_W-1:0]     seg_hundreds;
  logic [lmad_pkg::SEG_W-1:0]     seg_tens;
  logic [lmad_pkg::SEG_W-1:0]     seg_units;
  logic [1:0]                     light_level;
  logic                           saturated;

  modport source (
    output valid, output lux, output seg_thousands, output seg_hundreds,
    output seg_tens, output seg_units, output light_level, output saturated,
    input ready
  );
  modport sink (
    input valid, input lux, input seg_thousands, input seg_hundreds,
    input seg_tens, input seg_units, input light_level, input saturated,
    output ready
  );
endinterface

// ===== hdl/lmad_div.sv =====
module lmad_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lmad_pkg::NUM_HI_W-1:0] rem_init_i,
  input  logic [lmad_pkg::QUO_W-1:0]    dvd_init_i,
  input  logic [lmad_pkg::DEN_W-1:0]    dvs_init_i,
  output logic                          busy_o,
  output logic [lmad_pkg::QUO_W-1:0]    quo_o
);

  localparam int unsigned CntW = $clog2(lmad_pkg::QUO_W + 1);

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [lmad_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [lmad_pkg::QUO_W-1:0]      dvd_q, dvd_d;
  logic [lmad_pkg::DEN_W-1:0]      dvs_q, dvs_d;
  logic [lmad_pkg::REM_W-1:0]      rem_sh;
  logic [lmad_pkg::REM_W-1:0]      rem_sub;
  logic                            fits;

  assign busy_o = (cnt_q != '0);
  assign quo_o  = dvd_q;

  // restoring step: quotient bits shift in behind the dividend
  assign rem_sh  = {rem_q[lmad_pkg::REM_W-2:0], dvd_q[lmad_pkg::QUO_W-1]};
  assign fits    = (rem_sh >= lmad_pkg::REM_W'(dvs_q));
  assign rem_sub = rem_sh - lmad_pkg::REM_W'(dvs_q);

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(lmad_pkg::QUO_W);
      rem_d = lmad_pkg::REM_W'(rem_init_i);
      dvd_d = dvd_init_i;
      dvs_d = dvs_init_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? rem_sub : rem_sh;
      dvd_d = {dvd_q[lmad_pkg::QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

endmodule

// ===== hdl/lmad_dp.sv =====
module lmad_dp #(
  parameter int unsigned SAMPLE_BITS = lmad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lmad_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lmad_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  input  lmad_pkg::cmd_t                 cmd_i,
  output lmad_pkg::sts_t                 sts_o,
  output logic [lmad_pkg::LUX_W-1:0]     lux_o,
  output logic [lmad_pkg::SEG_W-1:0]     seg_thousands_o,
  output logic [lmad_pkg::SEG_W-1:0]     seg_hundreds_o,
  output logic [lmad_pkg::SEG_W-1:0]     seg_tens_o,
  output logic [lmad_pkg::SEG_W-1:0]     seg_units_o,
  output logic [1:0]                     light_level_o,
  output logic                           saturated_o
);

  logic [lmad_pkg::WIN_W-1:0] window_q;
  logic [lmad_pkg::LIM_W-1:0] dark_q;
  logic [lmad_pkg::LIM_W-1:0] bright_q;
  logic [lmad_pkg::SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [lmad_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_new;
  logic [lmad_pkg::WIN_W-1:0] win_eff;

  logic [lmad_pkg::PRD_W-1:0] prd_q;
  logic [lmad_pkg::DEN_W-1:0] den_q;
  logic [lmad_pkg::NUM_W-1:0] num_q;
  logic [lmad_pkg::PRD_W-1:0] diff;
  logic                       avgz_q;
  logic                       over_q;

  logic [lmad_pkg::LUX_W-1:0] lux_q, lux_d;
  logic                       sat_q, sat_d;
  logic [lmad_pkg::LUX_W-1:0] rem_q, rem_nx;
  logic [lmad_pkg::DIG_W-1:0] d_thou_q, d_hund_q, d_tens_q, dig;
  logic [lmad_pkg::LUX_W-1:0] wgt, sub;

  logic                       div_start;
  logic                       div_busy;
  logic [lmad_pkg::NUM_HI_W-1:0] div_rem_init;
  logic [lmad_pkg::QUO_W-1:0] div_dvd_init;
  logic [lmad_pkg::DEN_W-1:0] div_dvs_init;
  logic [lmad_pkg::QUO_W-1:0] quo;

  logic [lmad_pkg::LUX_W-1:0] out_lux_q;
  logic [lmad_pkg::SEG_W-1:0] out_seg3_q, out_seg2_q, out_seg1_q, out_seg0_q;
  lmad_pkg::level_e           out_lvl_q, lvl;
  logic                       out_sat_q;

  // window length 0 acts as 1, above 64 as 64
  always_comb begin
    if (window_q == '0) begin
      win_eff = lmad_pkg::WIN_W'(1);
    end else if (window_q > lmad_pkg::WIN_MAX) begin
      win_eff = lmad_pkg::WIN_MAX;
    end else begin
      win_eff = window_q;
    end
  end

  assign sum_new = sum_q + lmad_pkg::SUM_W'(sample_i);
  assign cnt_new = cnt_q + 1'b1;

  assign sts_o.close    = (cnt_new >= lmad_pkg::CNT_W'(win_eff));
  assign sts_o.div_busy = div_busy;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.acc_en) begin
      sum_d = sts_o.close ? '0 : sum_new;
      cnt_d = sts_o.close ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= lmad_pkg::WIN_RESET;
      dark_q   <= lmad_pkg::DARK_RESET;
      bright_q <= lmad_pkg::BRIGHT_RESET;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lmad_pkg::CFG_WINDOW: window_q <= cfg_data_i[lmad_pkg::WIN_W-1:0];
          lmad_pkg::CFG_DARK:   dark_q   <= cfg_data_i[lmad_pkg::LIM_W-1:0];
          lmad_pkg::CFG_BRIGHT: bright_q <= cfg_data_i[lmad_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // shared divider: mean first, then the lux quotient
  // num < 2^28 and den >= 4888 for a nonzero mean, so the top 12 quotient bits are zero
  assign div_start = cmd_i.div_avg_start | cmd_i.div_lux_start;

  always_comb begin
    if (cmd_i.div_avg_start) begin
      div_rem_init = '0;
      div_dvd_init = sum_new;
      div_dvs_init = lmad_pkg::DEN_W'(win_eff);
    end else begin
      div_rem_init = num_q[lmad_pkg::NUM_W-1:lmad_pkg::QUO_W];
      div_dvd_init = num_q[lmad_pkg::QUO_W-1:0];
      div_dvs_init = den_q;
    end
  end

  lmad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dvd_init_i (div_dvd_init),
    .dvs_init_i (div_dvs_init),
    .busy_o     (div_busy),
    .quo_o      (quo)
  );

  assign diff = lmad_pkg::K_VREF - prd_q;

  always_comb begin
    if (avgz_q) begin
      lux_d = lmad_pkg::LUX_MAX;
      sat_d = 1'b1;
    end else if (over_q) begin
      lux_d = '0;
      sat_d = 1'b0;
    end else if (quo > lmad_pkg::QUO_W'(lmad_pkg::LUX_MAX)) begin
      lux_d = lmad_pkg::LUX_MAX;
      sat_d = 1'b1;
    end else begin
      lux_d = quo[lmad_pkg::LUX_W-1:0];
      sat_d = 1'b0;
    end
  end

  // one decimal digit per step by parallel compare against k*weight
  always_comb begin
    logic [lmad_pkg::LUX_W-1:0] thr;
    case (cmd_i.digit_sel)
      lmad_pkg::DSEL_THOU: wgt = 14'd1000;
      lmad_pkg::DSEL_HUND: wgt = 14'd100;
      lmad_pkg::DSEL_TENS: wgt = 14'd10;
      default:             wgt = 14'd10;
    endcase
    dig = '0;
    sub = '0;
    thr = '0;
    for (int k = 1; k < 10; k++) begin
      thr = lmad_pkg::LUX_W'(k) * wgt;
      if (rem_q >= thr) begin
        dig = lmad_pkg::DIG_W'(k);
        sub = thr;
      end
    end
    rem_nx = rem_q - sub;
  end

  always_comb begin
    if (lux_q < dark_q) begin
      lvl = lmad_pkg::LVL_DARK;
    end else if (lux_q < bright_q) begin
      lvl = lmad_pkg::LVL_MEDIUM;
    end else begin
      lvl = lmad_pkg::LVL_LIGHT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prd_q  <= lmad_pkg::PRD_W'(quo) * lmad_pkg::K_VSTEP;
      den_q  <= lmad_pkg::DEN_W'(quo) * lmad_pkg::K_DEN;
      avgz_q <= (quo == '0);
    end
    if (cmd_i.num_en) begin
      over_q <= (prd_q >= lmad_pkg::K_VREF);
      num_q  <= (prd_q >= lmad_pkg::K_VREF) ? '0 :
                lmad_pkg::NUM_W'(diff) * lmad_pkg::K_GAIN;
    end
    if (cmd_i.clip_en) begin
      lux_q <= lux_d;
      sat_q <= sat_d;
      rem_q <= lux_d;
    end
    if (cmd_i.digit_en) begin
      rem_q <= rem_nx;
      case (cmd_i.digit_sel)
        lmad_pkg::DSEL_THOU: d_thou_q <= dig;
        lmad_pkg::DSEL_HUND: d_hund_q <= dig;
        lmad_pkg::DSEL_TENS: d_tens_q <= dig;
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      out_lux_q  <= lux_q;
      out_seg3_q <= (d_thou_q == '0) ? lmad_pkg::SEG_BLANK : lmad_pkg::seg_code(d_thou_q);
      out_seg2_q <= (lux_q < 14'd100) ? lmad_pkg::SEG_BLANK : lmad_pkg::seg_code(d_hund_q);
      out_seg1_q <= (lux_q < 14'd10) ? lmad_pkg::SEG_BLANK : lmad_pkg::seg_code(d_tens_q);
      out_seg0_q <= lmad_pkg::seg_code(rem_q[lmad_pkg::DIG_W-1:0]);
      out_lvl_q  <= lvl;
      out_sat_q  <= sat_q;
    end
  end

  assign lux_o           = out_lux_q;
  assign seg_thousands_o = out_seg3_q;
  assign seg_hundreds_o  = out_seg2_q;
  assign seg_tens_o      = out_seg1_q;
  assign seg_units_o     = out_seg0_q;
  assign light_level_o   = out_lvl_q;
  assign saturated_o     = out_sat_q;

  a_sat_clips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clip_en |=> (!sat_q || lux_q == lmad_pkg::LUX_MAX))
    else $error("saturated result not clipped");

endmodule

// ===== hdl/lmad_ctrl.sv =====
module lmad_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lmad_pkg::sts_t sts_i,
  output lmad_pkg::cmd_t cmd_o
);

  lmad_pkg::state_e state_q, state_d;
  lmad_pkg::dsel_e  step_q, step_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmad_pkg::ST_IDLE;
      step_q      <= lmad_pkg::DSEL_THOU;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    cmd_o            = '0;
    cmd_o.digit_sel  = step_q;
    in_ready_o       = 1'b0;
    case (state_q)
      lmad_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (sts_i.close) begin
            cmd_o.div_avg_start = 1'b1;
            state_d             = lmad_pkg::ST_DIV_AVG;
          end
        end
      end
      lmad_pkg::ST_DIV_AVG: begin
        if (!sts_i.div_busy) begin
          cmd_o.prod_en = 1'b1;
          state_d       = lmad_pkg::ST_NUM;
        end
      end
      lmad_pkg::ST_NUM: begin
        cmd_o.num_en = 1'b1;
        state_d      = lmad_pkg::ST_LUX_START;
      end
      lmad_pkg::ST_LUX_START: begin
        cmd_o.div_lux_start = 1'b1;
        state_d             = lmad_pkg::ST_DIV_LUX;
      end
      lmad_pkg::ST_DIV_LUX: begin
        if (!sts_i.div_busy) begin
          cmd_o.clip_en = 1'b1;
          step_d        = lmad_pkg::DSEL_THOU;
          state_d       = lmad_pkg::ST_DIGIT;
        end
      end
      lmad_pkg::ST_DIGIT: begin
        cmd_o.digit_en = 1'b1;
        case (step_q)
          lmad_pkg::DSEL_THOU: step_d = lmad_pkg::DSEL_HUND;
          lmad_pkg::DSEL_HUND: step_d = lmad_pkg::DSEL_TENS;
          default: begin
            step_d  = lmad_pkg::DSEL_THOU;
            state_d = lmad_pkg::ST_OUT;
          end
        endcase
      end
      lmad_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = lmad_pkg::ST_IDLE;
        end
      end
      default: state_d = lmad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_avg_start || cmd_o.div_lux_start) |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_avg_start || cmd_o.div_lux_start) |=> sts_i.div_busy)
    else $error("divider did not start");

endmodule

// ===== hdl/light_meter_average_and_digit_drive.sv =====
// Light meter: sums a window of window_length sensor samples (0 acts as 1, above 64 as 64),
// takes the truncated mean and converts it to lux = 500*(500000-488*avg)/(4888*avg),
// clipped to 9999 with the saturated flag (also set for a zero mean). Each result carries
// lux, four common-anode segment codes with leading-zero blanking and a dark/medium/light
// class. Samples that do not close a window are taken one per cycle and give no result.
// The sample that closes a window stalls the input until its result reaches the output
// register: one shared 16-step restoring divider runs twice (mean, then lux quotient),
// with two multiply steps, three digit steps and the output load around it. The stall
// grows while an earlier result still waits at the output. The output register lets the
// next window fill while a result waits.
module light_meter_average_and_digit_drive #(
  parameter int unsigned SAMPLE_BITS = lmad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lmad_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lmad_pkg::CFG_W-1:0]     cfg_data_i,
  lmad_in_if.sink                        sample_i,
  lmad_out_if.source                     result_o
);

  lmad_pkg::cmd_t cmd;
  lmad_pkg::sts_t sts;

  lmad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmad_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i.sample),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .lux_o           (result_o.lux),
    .seg_thousands_o (result_o.seg_thousands),
    .seg_hundreds_o  (result_o.seg_hundreds),
    .seg_tens_o      (result_o.seg_tens),
    .seg_units_o     (result_o.seg_units),
    .light_level_o   (result_o.light_level),
    .saturated_o     (result_o.saturated)
  );

endmodule

// ===== tb/light_meter_average_and_digit_drive_tb.sv =====
module light_meter_average_and_digit_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmad_pkg::*;

  localparam int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF;
  localparam int          READING_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int          CLK_HALF        = 10;
  localparam int          RESET_CYCLES    = 10;
  localparam int          DRAIN_CYCLES    = 64;
  localparam int          HOLD_CYCLES     = 600;
  localparam int          RANDOM_READINGS = 700;
  localparam int          MAX_REPORTS     = 10;
  localparam int          MAX_GAP         = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  localparam longint unsigned VOLT_STEP = 488;
  localparam longint unsigned VOLT_REF  = 500000;
  localparam longint unsigned LUX_GAIN  = 500;
  localparam longint unsigned LUX_DIV   = 4888;
  localparam int unsigned     LUX_CAP   = 9999;

  localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [SAMPLE_BITS-1:0] EDGE_READINGS [11] = '{
    10'd0, 10'd1, 10'd5, 10'd6, 10'd10, 10'd49, 10'd100, 10'd343, 10'd512, 10'd852,
    10'd1023
  };

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic [SEG_W-1:0] seg_thousands;
    logic [SEG_W-1:0] seg_hundreds;
    logic [SEG_W-1:0] seg_tens;
    logic [SEG_W-1:0] seg_units;
    logic [1:0]       light_level;
    logic             saturated;
  } lux_readout_t;

  function automatic string show(lux_readout_t r);
    return $sformatf("lux=%0d seg=%h/%h/%h/%h level=%0d sat=%b", r.lux, r.seg_thousands,
                     r.seg_hundreds, r.seg_tens, r.seg_units, r.light_level, r.saturated);
  endfunction

  class lux_readout_tracker;
    logic [WIN_W-1:0] win_len;
    logic [LIM_W-1:0] dark_lim;
    logic [LIM_W-1:0] bright_lim;
    logic [SUM_W-1:0] win_sum;
    logic [CNT_W-1:0] win_fill;
    lux_readout_t     readouts_due[$];
    int               mismatches;

    function new();
      win_len        = WIN_RESET;
      dark_lim       = DARK_RESET;
      bright_lim     = BRIGHT_RESET;
      win_sum        = '0;
      win_fill       = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WINDOW: win_len = data[WIN_W-1:0];
        CFG_DARK:   dark_lim = data[LIM_W-1:0];
        CFG_BRIGHT: bright_lim = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_reading(logic [SAMPLE_BITS-1:0] reading);
      int unsigned     win;
      int unsigned     avg;
      int unsigned     lux;
      longint unsigned num;
      longint unsigned den;
      lux_readout_t    r;
      win = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : win_len);
      win_sum  = win_sum + reading;
      win_fill = win_fill + 1'b1;
      if (win_fill < win) return;
      avg      = win_sum / win;
      win_sum  = '0;
      win_fill = '0;
      r.saturated = 1'b0;
      if (avg == 0) begin
        lux = LUX_CAP;
        r.saturated = 1'b1;
      end else if (VOLT_STEP * avg >= VOLT_REF) begin
        lux = 0;
      end else begin
        num = LUX_GAIN * (VOLT_REF - VOLT_STEP * avg);
        den = LUX_DIV * avg;
        if (num / den > LUX_CAP) begin
          lux = LUX_CAP;
          r.saturated = 1'b1;
        end else begin
          lux = int'(num / den);
        end
      end
      r.lux           = LUX_W'(lux);
      r.seg_thousands = (lux / 1000 == 0) ? SEG_BLANK : DIGIT_SEG[lux / 1000];
      r.seg_hundreds  = (lux < 100) ? SEG_BLANK : DIGIT_SEG[(lux / 100) % 10];
      r.seg_tens      = (lux < 10) ? SEG_BLANK : DIGIT_SEG[(lux / 10) % 10];
      r.seg_units     = DIGIT_SEG[lux % 10];
      if (lux < dark_lim) r.light_level = LVL_DARK;
      else if (lux < bright_lim) r.light_level = LVL_MEDIUM;
      else r.light_level = LVL_LIGHT;
      readouts_due.push_back(r);
    endfunction

    function void check_readout(lux_readout_t got);
      lux_readout_t want;
      if (readouts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected readout: %s", show(got));
        return;
      end
      want = readouts_due.pop_front();
      if (got.lux !== want.lux || got.seg_thousands !== want.seg_thousands ||
          got.seg_hundreds !== want.seg_hundreds || got.seg_tens !== want.seg_tens ||
          got.seg_units !== want.seg_units || got.light_level !== want.light_level ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("readout mismatch at %0t\n  expected %s\n  actual   %s", $realtime,
                   show(want), show(got));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;
  int                   readings_sent = 0;

  lux_readout_tracker tracker = new();

  lmad_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) reading_if ();
  lmad_out_if readout_if ();

  light_meter_average_and_digit_drive #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (reading_if),
    .result_o   (readout_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    tracker.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_reading(input logic [SAMPLE_BITS-1:0] reading);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      reading_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    reading_if.valid  <= 1'b1;
    reading_if.sample <= reading;
    do @(posedge clk_i); while (reading_if.ready !== 1'b1);
    tracker.take_reading(reading);
    readings_sent++;
  endtask

  // wait for the block to drain before touching registers
  task automatic settle();
    reading_if.valid <= 1'b0;
    while (tracker.readouts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    readout_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        readout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      readout_if.ready <= 1'b1;
      do @(posedge clk_i); while (readout_if.valid !== 1'b1);
      tracker.check_readout('{lux:           readout_if.lux,
                              seg_thousands: readout_if.seg_thousands,
                              seg_hundreds:  readout_if.seg_hundreds,
                              seg_tens:      readout_if.seg_tens,
                              seg_units:     readout_if.seg_units,
                              light_level:   readout_if.light_level,
                              saturated:     readout_if.saturated});
    end
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned center;
    int unsigned spread;
    int unsigned wlen;
    int unsigned dark;
    int unsigned bright;
    int unsigned count;
    int unsigned phase;
    int          v;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    reading_if.valid  <= 1'b0;
    reading_if.sample <= '0;
    rst_ni            <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one reading per window: saturation, blanking and every digit range
    cfg_write(CFG_WINDOW, 14'd1);
    foreach (EDGE_READINGS[i]) send_reading(EDGE_READINGS[i]);
    settle();
    cfg_write(CFG_DARK, 14'd0);
    cfg_write(CFG_BRIGHT, 14'h3FFF);
    send_reading(10'd1023);
    send_reading(10'd6);
    settle();
    // crossed limits
    cfg_write(CFG_DARK, 14'd9999);
    cfg_write(CFG_BRIGHT, 14'd0);
    send_reading(10'd6);
    send_reading(10'd1023);
    send_reading(10'd1);
    settle();
    cfg_write(CFG_WINDOW, 14'd0);
    send_reading(10'd300);
    send_reading(10'd700);
    settle();
    // shrink the window with two readings already summed
    cfg_write(CFG_WINDOW, 14'd3);
    send_reading(10'd100);
    send_reading(10'd200);
    settle();
    cfg_write(CFG_WINDOW, 14'd2);
    send_reading(10'd300);
    settle();
    cfg_write(CFG_IDX_UNUSED, 14'h3FFF);
    send_reading(10'd0);
    send_reading(10'd0);

    readings_sent = 0;
    phase  = 0;
    center = READING_MAX / 2;
    spread = READING_MAX / 2;
    while (readings_sent < RANDOM_READINGS) begin
      settle();
      if (phase == 0) begin
        wlen = 1;
      end else begin
        case ($urandom_range(0, 6))
          0:       wlen = 1;
          1:       wlen = $urandom_range(2, 4);
          2:       wlen = $urandom_range(5, 16);
          3:       wlen = $urandom_range(17, 63);
          4:       wlen = 64;
          5:       wlen = 0;
          default: wlen = $urandom_range(65, 127);
        endcase
      end
      cfg_write(CFG_WINDOW, {7'($urandom_range(0, 127)), 7'(wlen)});
      case ($urandom_range(0, 3))
        0: begin
          dark   = $urandom_range(0, LUX_CAP);
          bright = $urandom_range(dark, LUX_CAP);
        end
        1: begin
          bright = $urandom_range(0, LUX_CAP);
          dark   = $urandom_range(bright, LUX_CAP);
        end
        2: begin
          dark   = $urandom_range(0, 1) ? 16383 : 0;
          bright = $urandom_range(0, 1) ? 16383 : LUX_CAP;
        end
        default: begin
          dark   = $urandom_range(0, 16383);
          bright = $urandom_range(0, 16383);
        end
      endcase
      cfg_write(CFG_DARK, LIM_W'(dark));
      cfg_write(CFG_BRIGHT, LIM_W'(bright));
      // first phase: back-to-back readings against a long output stall
      quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
      if (phase == 0) hold_req = 1'b1;
      count = (phase == 0) ? 80 : $urandom_range(40, 120);
      repeat (count) begin
        if (tracker.win_fill == 0) begin
          case ($urandom_range(0, 6))
            0: begin center = 0; spread = 0; end
            1: begin center = $urandom_range(1, 8); spread = 1; end
            2: begin center = $urandom_range(6, 60); spread = 5; end
            3: begin center = $urandom_range(60, 350); spread = 30; end
            4: begin center = $urandom_range(350, 860); spread = 60; end
            5: begin center = $urandom_range(860, READING_MAX); spread = 40; end
            default: begin center = READING_MAX / 2; spread = READING_MAX / 2 + 1; end
          endcase
        end
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0) v = 0;
        else if (v > READING_MAX) v = READING_MAX;
        send_reading(v[SAMPLE_BITS-1:0]);
      end
      phase++;
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lmad_pkg.sv
hdl/lmad_intf.sv
hdl/lmad_div.sv
hdl/lmad_dp.sv
hdl/lmad_ctrl.sv
hdl/light_meter_average_and_digit_drive.sv
tb/light_meter_average_and_digit_drive_tb.sv
